FILE: src/cte_pkg.sv
// Package for the columnar transposition encryptor.
// Holds the channel payload types, the controller state type and fixed constants.
// No dependencies.
package cte_pkg;

    // Fixed field and register widths.
    localparam int CH_W          = 8;
    localparam int KEY_LEN_W     = 4;
    localparam int KEY_ORDER_W   = 24;
    localparam int COL_W         = 3;
    localparam int KEY_POSITIONS = 8;
    localparam int CFG_DATA_W    = 24;
    localparam int CFG_INDEX_W   = 1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_LEN   = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_ORDER = 1'b1;

    // Reset value of the key length register.
    localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 4'd1;

    // Input item.
    typedef struct packed {
        logic [CH_W-1:0] ch;
        logic            last;
    } cte_in_t;

    // Result item.
    typedef struct packed {
        logic [CH_W-1:0] out_ch;
        logic            out_last;
        logic            overflow;
    } cte_out_t;

    // Flags that travel alongside a buffer read.
    typedef struct packed {
        logic out_last;
        logic overflow;
    } cte_tag_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_EMIT
    } cte_state_t;

endpackage

FILE: src/columnar_transposition_encrypt_top.sv
// Top level of the columnar transposition encryptor.
// Depends on cte_pkg, cte_ctrl, cte_grid_ram and cte_out_queue.
//
//  Channel   Handshake                    Payload
//  input     valid / ready                data   (cte_in_t: ch, last)
//  output    result_valid / result_ready  result (cte_out_t: out_ch, out_last, overflow)
//  config    cfg_write                    cfg_index, cfg_data
//
// Plaintext bytes load one per cycle into the buffer RAM while the controller is loading.
// After the last byte, a scan over the key positions precedes the read-out;
// the read-out then reads one buffer cell per emitted byte through the single RAM read
// port and skips key positions that name no filled column, so input stalls for the scan
// plus the read-out; with no filled column only the scan runs.
// Output stalls hold the read-out through a two-entry queue; reset is asynchronous, active low.
module columnar_transposition_encrypt_top
    import cte_pkg::*;
#(
    parameter int MAX_SIDE = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   valid,
    output logic                   ready,
    input  cte_in_t                data,
    output logic                   result_valid,
    input  logic                   result_ready,
    output cte_out_t               result
);

    localparam int AW = $clog2(MAX_SIDE * MAX_SIDE);

    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic [CH_W-1:0] wr_data;
    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    logic [CH_W-1:0] rd_data;
    logic            push;
    cte_tag_t        push_tag;
    cte_out_t        push_item;
    logic [1:0]      q_level;
    logic            q_pop;

    assign q_pop = result_valid && result_ready;

    // Sequencer for loading and read-out.
    cte_ctrl #(
        .MAX_SIDE (MAX_SIDE)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (valid),
        .in_ready  (ready),
        .in_item   (data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .push      (push),
        .push_tag  (push_tag),
        .q_level   (q_level),
        .q_pop     (q_pop)
    );

    // Message buffer.
    cte_grid_ram #(
        .MAX_SIDE (MAX_SIDE)
    ) u_grid (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Join returning data with its flags.
    always_comb
    begin
        push_item.out_ch   = rd_data;
        push_item.out_last = push_tag.out_last;
        push_item.overflow = push_tag.overflow;
    end

    // Result queue toward the output channel.
    cte_out_queue u_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .push_item    (push_item),
        .result       (result),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .level        (q_level)
    );

endmodule

FILE: src/cte_grid_ram.sv
// Square message buffer: one write port and one read port with registered read data.
// Depends on cte_pkg for the byte width.
module cte_grid_ram
    import cte_pkg::*;
#(
    parameter int MAX_SIDE = 8
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0]   wr_addr,
    input  logic [CH_W-1:0]                        wr_data,
    input  logic                                   rd_en,
    input  logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0]   rd_addr,
    output logic [CH_W-1:0]                        rd_data
);

    localparam int DEPTH = MAX_SIDE * MAX_SIDE;

    logic [CH_W-1:0] mem [DEPTH];
    logic [CH_W-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; read data are registered and appear in the cycle after rd_en.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/cte_out_queue.sv
// Two-entry result queue that decouples buffer reads from the output handshake.
// Depends on cte_pkg for the result type.
module cte_out_queue
    import cte_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  cte_out_t  push_item,
    output cte_out_t  result,
    output logic      result_valid,
    input  logic      result_ready,
    output logic [1:0] level
);

    cte_out_t   slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       pop;

    assign result_valid = (count_reg != 2'd0);
    assign pop          = result_valid && result_ready;
    assign result       = slot_reg[rd_ptr_reg];
    assign level        = count_reg;

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: src/cte_ctrl.sv
// Controller: configuration registers, message loading and the column read-out walk.
// Depends on cte_pkg for types, widths and register indexes.
module cte_ctrl
    import cte_pkg::*;
#(
    parameter int MAX_SIDE = 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [CFG_INDEX_W-1:0]                cfg_index,
    input  logic [CFG_DATA_W-1:0]                 cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  cte_in_t                               in_item,
    output logic                                  wr_en,
    output logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0]  wr_addr,
    output logic [CH_W-1:0]                       wr_data,
    output logic                                  rd_en,
    output logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0]  rd_addr,
    output logic                                  push,
    output cte_tag_t                              push_tag,
    input  logic [1:0]                            q_level,
    input  logic                                  q_pop
);

    localparam int AW   = $clog2(MAX_SIDE * MAX_SIDE);
    localparam int CNTW = $clog2(MAX_SIDE * MAX_SIDE + 1);
    localparam int SW   = $clog2(MAX_SIDE + 1);
    localparam int PW   = $clog2(MAX_SIDE);

    // Column named by a key position; positions past the key field name column 0.
    function automatic logic [COL_W-1:0] col_of(input logic [PW-1:0] p,
                                                input logic [KEY_ORDER_W-1:0] ko);
        logic [COL_W-1:0] c;
        c = '0;
        for (int k = 0; k < KEY_POSITIONS; k++)
        begin
            if (32'(p) == k)
            begin
                c = ko[k*COL_W +: COL_W];
            end
        end
        return c;
    endfunction

    logic [KEY_LEN_W-1:0]   key_len_reg;
    logic [KEY_ORDER_W-1:0] key_order_reg;
    cte_state_t             state_reg, state_next;
    logic [CNTW-1:0]        cnt_reg, cnt_next;
    logic                   flag_reg, flag_next;
    logic [PW-1:0]          pos_reg, pos_next;
    logic [SW-1:0]          row_reg, row_next;
    logic [CNTW-1:0]        idx_reg, idx_next;
    logic                   found_reg, found_next;
    logic [PW-1:0]          lpos_reg, lpos_next;
    logic                   pend_reg;
    cte_tag_t               tag_reg, tag_next;

    logic [SW-1:0]          side;
    logic [CNTW-1:0]        cells;
    logic [COL_W-1:0]       cur_col;
    logic [COL_W-1:0]       next_col;
    logic                   cur_ok;
    logic                   col_done;
    logic                   pos_last;
    logic                   credit;
    logic                   adv;
    logic                   in_fire;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_len_reg   <= KEY_LEN_RESET;
            key_order_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_KEY_LEN:   key_len_reg   <= cfg_data[KEY_LEN_W-1:0];
                REG_KEY_ORDER: key_order_reg <= cfg_data[KEY_ORDER_W-1:0];
                default:       ;
            endcase
        end
    end

    // Effective side of the square, clamped to one through MAX_SIDE.
    always_comb
    begin
        if (key_len_reg == '0)
        begin
            side = SW'(1);
        end
        else if (32'(key_len_reg) > MAX_SIDE)
        begin
            side = SW'(MAX_SIDE);
        end
        else
        begin
            side = SW'(key_len_reg);
        end
        cells = CNTW'(side) * CNTW'(side);
    end

    // Column decode and walk conditions for the current key position.
    assign cur_col  = col_of(pos_reg, key_order_reg);
    assign next_col = col_of(PW'(pos_reg + 1'b1), key_order_reg);
    assign cur_ok   = (32'(cur_col) < 32'(side)) && (32'(cur_col) < 32'(cnt_reg));
    assign col_done = (32'(row_reg) == 32'(side) - 1) ||
                      (32'(idx_reg) + 32'(side) >= 32'(cnt_reg));
    assign pos_last = (32'(pos_reg) == 32'(side) - 1);

    // A read may issue when the queue will have room for its data.
    assign credit = (3'(q_level) + 3'(pend_reg)) < (3'd2 + 3'(q_pop));

    assign in_ready = (state_reg == ST_LOAD);
    assign in_fire  = in_valid && in_ready;

    // Next state, counters and memory requests.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        flag_next  = flag_reg;
        pos_next   = pos_reg;
        row_next   = row_reg;
        idx_next   = idx_reg;
        found_next = found_reg;
        lpos_next  = lpos_reg;
        tag_next   = tag_reg;
        wr_en      = 1'b0;
        wr_addr    = cnt_reg[AW-1:0];
        wr_data    = in_item.ch;
        rd_en      = 1'b0;
        rd_addr    = idx_reg[AW-1:0];
        adv        = 1'b0;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_fire)
                begin
                    if (cnt_reg < cells)
                    begin
                        wr_en    = 1'b1;
                        cnt_next = cnt_reg + 1'b1;
                    end
                    else
                    begin
                        flag_next = 1'b1;
                    end
                    if (in_item.last)
                    begin
                        state_next = ST_SCAN;
                        pos_next   = '0;
                        found_next = 1'b0;
                    end
                end
            end

            // Find the last key position that names a filled column.
            ST_SCAN:
            begin
                if (cur_ok)
                begin
                    found_next = 1'b1;
                    lpos_next  = pos_reg;
                end
                if (pos_last)
                begin
                    if (found_reg || cur_ok)
                    begin
                        state_next = ST_EMIT;
                        pos_next   = '0;
                        row_next   = '0;
                        idx_next   = CNTW'(col_of('0, key_order_reg));
                    end
                    else
                    begin
                        state_next = ST_LOAD;
                        cnt_next   = '0;
                        flag_next  = 1'b0;
                    end
                end
                else
                begin
                    pos_next = PW'(pos_reg + 1'b1);
                end
            end

            // Walk each named column from the top, one cell per read.
            ST_EMIT:
            begin
                if (!cur_ok)
                begin
                    adv = 1'b1;
                end
                else if (credit)
                begin
                    rd_en             = 1'b1;
                    tag_next.out_last = (pos_reg == lpos_reg) && col_done;
                    tag_next.overflow = flag_reg;
                    if (col_done)
                    begin
                        adv = 1'b1;
                    end
                    else
                    begin
                        row_next = row_reg + 1'b1;
                        idx_next = idx_reg + CNTW'(side);
                    end
                end
                if (adv)
                begin
                    if (pos_last)
                    begin
                        state_next = ST_LOAD;
                        cnt_next   = '0;
                        flag_next  = 1'b0;
                    end
                    else
                    begin
                        pos_next = PW'(pos_reg + 1'b1);
                        row_next = '0;
                        idx_next = CNTW'(next_col);
                    end
                end
            end

            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            cnt_reg   <= '0;
            flag_reg  <= 1'b0;
            pos_reg   <= '0;
            row_reg   <= '0;
            idx_reg   <= '0;
            found_reg <= 1'b0;
            lpos_reg  <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            flag_reg  <= flag_next;
            pos_reg   <= pos_next;
            row_reg   <= row_next;
            idx_reg   <= idx_next;
            found_reg <= found_next;
            lpos_reg  <= lpos_next;
            pend_reg  <= rd_en;
        end
    end

    // Flags of the read in flight, aligned with the returning data.
    always_ff @(posedge clk)
    begin
        tag_reg <= tag_next;
    end

    assign push     = pend_reg;
    assign push_tag = tag_reg;

endmodule
